// ===== hdl/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_FULL        = 2'd1;
    localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

    localparam logic [15:0] GC_MARGIN_RESET = 16'd256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_SUM,
        ST_ALLOC_WORD,
        ST_REL_WORD
    } state_t;

    typedef struct packed {
        logic        func;
        logic [14:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [14:0] granted_index;
        logic [1:0]  status;
        logic [15:0] in_use_count;
        logic        gc_needed;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/bsa_ram.sv =====
`default_nettype none

module bsa_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bsa_ffz.sv =====
`default_nettype none

module bsa_ffz #(
    parameter int N  = 64,
    parameter int IW = (N > 1) ? $clog2(N) : 1
)(
    input  logic [N-1:0]  bits,
    output logic          found,
    output logic [IW-1:0] idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bitmap_slot_allocator_top.sv =====
// Allocate runs ST_ALLOC_SUM then ST_ALLOC_WORD and release runs ST_REL_WORD before done;
// a full pool or bad release index is answered from ST_IDLE. One at a time; rejects every cycle.
// busy is low again in the cycle the done strobe is high; results are never stalled.
// Allocate does the summary read followed by the bitmap word read (one port each).
// rst_n is asynchronous; after release of reset a clearing pass writes every bitmap word
// with busy high; the margin register resets to 256.
`default_nettype none

module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int SLOTS = 32768
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        done,
    output rsp_t        rsp
);

    localparam int WORDS     = (SLOTS + 63) / 64;
    localparam int SUMROWS   = (WORDS + 63) / 64;
    localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RAW       = (SUMROWS > 1) ? $clog2(SUMROWS) : 1;
    localparam int CW        = $clog2(SLOTS + 1);
    localparam int LAST_BITS = SLOTS - (WORDS - 1) * 64;
    localparam int LAST_POS  = WORDS - (SUMROWS - 1) * 64;
    localparam logic [63:0] WORD_PAD =
        (LAST_BITS == 64) ? 64'd0 : ~((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [63:0] ROW_PAD =
        (LAST_POS == 64) ? 64'd0 : ~((64'd1 << LAST_POS) - 64'd1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [RAW-1:0] LAST_ROW  = RAW'(SUMROWS - 1);
    localparam logic [16:0]    SLOTS_W   = 17'(SLOTS);

    state_t              state_reg, state_next;
    logic [WAW-1:0]      clr_reg, clr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [15:0]         margin_reg;
    logic [SUMROWS-1:0]  top_full_reg, top_full_next;
    logic [RAW-1:0]      row_reg, row_next;
    logic [5:0]          pos_reg, pos_next;
    logic [WAW-1:0]      word_reg, word_next;
    logic [5:0]          bit_reg, bit_next;
    logic [63:0]         sum_reg, sum_next;
    logic                done_reg;
    rsp_t                rsp_reg;

    logic                bm_we;
    logic [WAW-1:0]      bm_waddr, bm_raddr;
    logic [63:0]         bm_wdata, bm_rdata;
    logic                sum_we;
    logic [RAW-1:0]      sum_waddr, sum_raddr;
    logic [63:0]         sum_wdata, sum_rdata;

    logic                top_found;
    logic [RAW-1:0]      top_idx;
    logic                sum_found;
    logic [5:0]          sum_idx;
    logic                bm_found;
    logic [5:0]          bm_idx;

    logic                emit;
    logic [14:0]         emit_granted;
    logic [1:0]          emit_status;
    logic [WAW-1:0]      rel_word;
    logic [RAW-1:0]      rel_row;
    logic                rel_bad;
    logic [WAW-1:0]      alloc_word;
    logic [63:0]         set_word;

    bsa_ram #(
        .DEPTH (WORDS),
        .WIDTH (64)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bsa_ram #(
        .DEPTH (SUMROWS),
        .WIDTH (64)
    ) u_summary (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    bsa_ffz #(.N(SUMROWS)) u_top_ffz (
        .bits  (top_full_reg),
        .found (top_found),
        .idx   (top_idx)
    );

    bsa_ffz #(.N(64)) u_sum_ffz (
        .bits  (sum_rdata),
        .found (sum_found),
        .idx   (sum_idx)
    );

    bsa_ffz #(.N(64)) u_bm_ffz (
        .bits  (bm_rdata),
        .found (bm_found),
        .idx   (bm_idx)
    );

    assign rel_word   = WAW'(req.slot_index >> 6);
    assign rel_row    = RAW'(rel_word >> 6);
    assign rel_bad    = (req.slot_index == 15'd0) || (17'(req.slot_index) >= SLOTS_W);
    assign alloc_word = WAW'({row_reg, sum_idx});
    assign set_word   = bm_rdata | (64'd1 << bm_idx);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        top_full_next = top_full_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        bit_next      = bit_reg;
        sum_next      = sum_reg;
        bm_we         = 1'b0;
        bm_waddr      = word_reg;
        bm_wdata      = '0;
        bm_raddr      = word_reg;
        sum_we        = 1'b0;
        sum_waddr     = row_reg;
        sum_wdata     = '0;
        sum_raddr     = row_reg;
        emit          = 1'b0;
        emit_granted  = '0;
        emit_status   = STATUS_OK;

        case (state_reg)
            ST_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                bm_wdata = ((clr_reg == '0) ? 64'd1 : 64'd0)
                         | ((clr_reg == LAST_WORD) ? WORD_PAD : 64'd0);
                if (32'(clr_reg) < SUMROWS)
                begin
                    sum_we    = 1'b1;
                    sum_waddr = RAW'(clr_reg);
                    sum_wdata = (RAW'(clr_reg) == LAST_ROW) ? ROW_PAD : 64'd0;
                end
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.func == FUNC_ALLOC)
                    begin
                        if (!top_found)
                        begin
                            emit        = 1'b1;
                            emit_status = STATUS_FULL;
                        end
                        else
                        begin
                            sum_raddr  = top_idx;
                            row_next   = top_idx;
                            state_next = ST_ALLOC_SUM;
                        end
                    end
                    else
                    begin
                        if (rel_bad)
                        begin
                            emit        = 1'b1;
                            emit_status = STATUS_BAD_RELEASE;
                        end
                        else
                        begin
                            bm_raddr   = rel_word;
                            sum_raddr  = rel_row;
                            word_next  = rel_word;
                            row_next   = rel_row;
                            pos_next   = 6'(rel_word);
                            bit_next   = req.slot_index[5:0];
                            state_next = ST_REL_WORD;
                        end
                    end
                end
            end
            ST_ALLOC_SUM:
            begin
                bm_raddr   = alloc_word;
                word_next  = alloc_word;
                pos_next   = sum_idx;
                sum_next   = sum_rdata;
                state_next = ST_ALLOC_WORD;
            end
            ST_ALLOC_WORD:
            begin
                bm_we    = 1'b1;
                bm_waddr = word_reg;
                bm_wdata = set_word;
                if (&set_word)
                begin
                    sum_we    = 1'b1;
                    sum_waddr = row_reg;
                    sum_wdata = sum_reg | (64'd1 << pos_reg);
                    if (&sum_wdata)
                    begin
                        top_full_next[row_reg] = 1'b1;
                    end
                end
                count_next   = count_reg + 1'b1;
                emit         = 1'b1;
                emit_granted = 15'({word_reg, bm_idx});
                state_next   = ST_IDLE;
            end
            ST_REL_WORD:
            begin
                emit       = 1'b1;
                state_next = ST_IDLE;
                if (!bm_rdata[bit_reg])
                begin
                    emit_status = STATUS_BAD_RELEASE;
                end
                else
                begin
                    bm_we    = 1'b1;
                    bm_waddr = word_reg;
                    bm_wdata = bm_rdata & ~(64'd1 << bit_reg);
                    if (&bm_rdata)
                    begin
                        sum_we    = 1'b1;
                        sum_waddr = row_reg;
                        sum_wdata = sum_rdata & ~(64'd1 << pos_reg);
                    end
                    top_full_next[row_reg] = 1'b0;
                    count_next             = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= CW'(1);
            margin_reg   <= GC_MARGIN_RESET;
            top_full_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            top_full_reg <= top_full_next;
            done_reg     <= emit;
            if (cfg_we)
            begin
                margin_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
        sum_reg  <= sum_next;
        if (emit)
        begin
            rsp_reg.granted_index <= emit_granted;
            rsp_reg.status        <= emit_status;
            rsp_reg.in_use_count  <= 16'(count_next);
            rsp_reg.gc_needed     <= (18'(count_next) + 18'(margin_reg)) > 18'(SLOTS);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !done_reg)
        else $error("result during clearing pass");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("accepted item neither in flight nor answered");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (32'(count_reg) <= SLOTS))
        else $error("in-use count out of range");

    a_summary_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_SUM) |-> sum_found)
        else $error("summary row marked free has no free word");

    a_word_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_WORD) |-> bm_found)
        else $error("word marked free in summary is full");
`endif

endmodule

`default_nettype wire
